// ===== hdl/wpe_pkg.sv =====
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types, codes, sine table and helpers of the wireframe expander.
// ----------------------------------------------------------------------------
package wpe_pkg;

  // default sizes of the vertex store and budgets
  localparam int unsigned VERTEX_DEPTH_DEF    = 32768;
  localparam int unsigned PRIMITIVE_LIMIT_DEF = 4096;
  localparam int unsigned MAX_SEGMENTS_DEF    = 64;
  localparam int unsigned MIN_SEGMENTS        = 8;

  // widths sized for the largest segment count (256)
  localparam int unsigned SEG_W  = 9;
  localparam int unsigned LINE_W = 10;
  localparam int unsigned QS_W   = 10;

  // sine table: quarter wave, Q1.16, 17-bit entries
  localparam int unsigned QUARTER    = 1024;
  localparam int unsigned TAB_ENT    = QUARTER + 1;
  localparam int unsigned TAB_BITS   = 17;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // request codes
  typedef enum logic [2:0] {
    FN_BEGIN, FN_POINT, FN_AXES, FN_BOX, FN_SPHERE, FN_EDGE, FN_READ, FN_NOP
  } func_e;

  // request as seen on the input port
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] size;
    logic [15:0]        segments;
    logic [31:0]        color;
    logic [14:0]        read_index;
  } wpe_req_t;

  // result as seen on the output port
  typedef struct packed {
    logic [15:0]        vertex_count;
    logic               truncated;
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
    logic signed [31:0] read_z;
    logic [31:0]        read_color;
  } wpe_rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    wpe_req_t          req;
    logic              draws;
    logic [SEG_W-1:0]  segs;
    logic [LINE_W-1:0] lines;
    logic [QS_W-1:0]   step_q;
    logic [SEG_W-1:0]  step_r;
  } wpe_cmd_t;

  // quarter-wave sine from a Taylor series, evaluated at elaboration
  function automatic logic [TAB_ENT*TAB_BITS-1:0] build_sine();
    logic [TAB_ENT*TAB_BITS-1:0] tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    tab = '0;
    for (int i = 0; i <= int'(QUARTER); i++) begin
      x  = (longint'(i) * PI_Q30) / (2 * QUARTER);
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      // odd terms x^3/3! .. x^15/15!, alternating sign
      t = ((t * x2) >> 30) / 64'd6;
      s = s - longint'(t);
      t = ((t * x2) >> 30) / 64'd20;
      s = s + longint'(t);
      t = ((t * x2) >> 30) / 64'd42;
      s = s - longint'(t);
      t = ((t * x2) >> 30) / 64'd72;
      s = s + longint'(t);
      t = ((t * x2) >> 30) / 64'd110;
      s = s - longint'(t);
      t = ((t * x2) >> 30) / 64'd156;
      s = s + longint'(t);
      t = ((t * x2) >> 30) / 64'd210;
      s = s - longint'(t);
      if (s < 0) s = 0;
      s = (s + 8192) / 16384;
      if (s > 65536) s = 65536;
      tab[i*TAB_BITS +: TAB_BITS] = TAB_BITS'(s);
    end
    return tab;
  endfunction

  localparam logic [TAB_ENT*TAB_BITS-1:0] SINE_FLAT = build_sine();

  // sine of a 12-bit phase: {negative, magnitude}
  function automatic logic [TAB_BITS:0] sine_at(input logic [11:0] p);
    logic [10:0] idx;
    idx = p[10] ? (11'(QUARTER) - {1'b0, p[9:0]}) : {1'b0, p[9:0]};
    return {p[11], SINE_FLAT[int'(idx)*TAB_BITS +: TAB_BITS]};
  endfunction

  // corners of box edge e, end point sel, as {z, y, x} take-maximum mask
  function automatic logic [2:0] box_corner(input logic [3:0] e, input logic sel);
    logic [2:0] c;
    case (e)
      4'd0:    c = sel ? 3'd1 : 3'd0;
      4'd1:    c = sel ? 3'd2 : 3'd1;
      4'd2:    c = sel ? 3'd3 : 3'd2;
      4'd3:    c = sel ? 3'd0 : 3'd3;
      4'd4:    c = sel ? 3'd5 : 3'd4;
      4'd5:    c = sel ? 3'd6 : 3'd5;
      4'd6:    c = sel ? 3'd7 : 3'd6;
      4'd7:    c = sel ? 3'd4 : 3'd7;
      4'd8:    c = sel ? 3'd4 : 3'd0;
      4'd9:    c = sel ? 3'd5 : 3'd1;
      4'd10:   c = sel ? 3'd6 : 3'd2;
      4'd11:   c = sel ? 3'd7 : 3'd3;
      default: c = 3'd0;
    endcase
    return {c[2], c[1], c[1] ^ c[0]};
  endfunction

  // saturating add of a coordinate and a signed offset
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] b,
                                                 input logic signed [32:0] o);
    logic signed [33:0] sum;
    sum = {{2{b[31]}}, b} + {o[32], o};
    if (sum > 34'sd2147483647) return 32'sh7fffffff;
    if (sum < -34'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

endpackage

// ===== hdl/wpe_ram.sv =====
// ----------------------------------------------------------------------------
// wpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/wpe_front.sv =====
// ----------------------------------------------------------------------------
// wpe_front
// Takes requests, clamps segments, works out the sphere phase step with a
// bit-serial divider and classifies the primitive for the back end.
// ----------------------------------------------------------------------------
module wpe_front #(
  parameter int unsigned MAX_SEGMENTS = wpe_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  wpe_pkg::wpe_req_t req_i,
  input  logic              full_i,
  output logic              push_o,
  output wpe_pkg::wpe_cmd_t cmd_o
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_e;

  localparam int unsigned SW = wpe_pkg::SEG_W;

  state_e            state_q, state_d;
  wpe_pkg::wpe_req_t req_q, req_d;
  logic [SW-1:0]     n_q, n_d;
  logic [13:0]       dvd_q, dvd_d;
  logic [13:0]       quo_q, quo_d;
  logic [SW:0]       rem_q, rem_d;
  logic [3:0]        cnt_q, cnt_d;

  logic [SW:0]       two_n;
  logic [SW+1:0]     trial;
  logic [SW-1:0]     n_clamp;
  logic              draws;
  logic [wpe_pkg::LINE_W-1:0] lines;

  // segment clamp
  always_comb begin
    if (req_i.segments < 16'(wpe_pkg::MIN_SEGMENTS)) begin
      n_clamp = SW'(wpe_pkg::MIN_SEGMENTS);
    end else if (req_i.segments > 16'(MAX_SEGMENTS)) begin
      n_clamp = SW'(MAX_SEGMENTS);
    end else begin
      n_clamp = SW'(req_i.segments);
    end
  end

  assign two_n = {n_q, 1'b0};
  assign trial = {rem_q, dvd_q[13]};

  // request hold, divider and push sequencing
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    n_d     = n_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          n_d   = n_clamp;
          dvd_d = 14'd8192;
          quo_d = '0;
          rem_d = '0;
          cnt_d = 4'd13;
          state_d = (req_i.func == wpe_pkg::FN_SPHERE) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        // one quotient bit of 8192 / 2n per cycle
        dvd_d = {dvd_q[12:0], 1'b0};
        if (trial >= {1'b0, two_n}) begin
          rem_d = (SW+1)'(trial - {1'b0, two_n});
          quo_d = {quo_q[12:0], 1'b1};
        end else begin
          rem_d = trial[SW:0];
          quo_d = {quo_q[12:0], 1'b0};
        end
        if (cnt_q == 4'd0) begin
          state_d = F_PUSH;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // classification
  always_comb begin
    draws = 1'b0;
    lines = '0;
    case (req_q.func)
      wpe_pkg::FN_POINT, wpe_pkg::FN_AXES: begin
        draws = (req_q.size > 0);
        lines = wpe_pkg::LINE_W'(3);
      end
      wpe_pkg::FN_BOX: begin
        draws = (req_q.first_x <= req_q.second_x) && (req_q.first_y <= req_q.second_y)
             && (req_q.first_z <= req_q.second_z);
        lines = wpe_pkg::LINE_W'(12);
      end
      wpe_pkg::FN_SPHERE: begin
        draws = (req_q.size > 0);
        lines = wpe_pkg::LINE_W'({n_q, 1'b0}) + wpe_pkg::LINE_W'(n_q);
      end
      wpe_pkg::FN_EDGE: begin
        draws = 1'b1;
        lines = wpe_pkg::LINE_W'(1);
      end
      default: begin
        draws = 1'b0;
        lines = '0;
      end
    endcase
  end

  assign cmd_o.req    = req_q;
  assign cmd_o.draws  = draws;
  assign cmd_o.segs   = n_q;
  assign cmd_o.lines  = lines;
  assign cmd_o.step_q = wpe_pkg::QS_W'(quo_q);
  assign cmd_o.step_r = SW'(rem_q);
  assign busy_o       = (state_q != F_IDLE);

  // state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    n_q   <= n_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

endmodule

// ===== hdl/wpe_queue.sv =====
// ----------------------------------------------------------------------------
// wpe_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module wpe_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wpe_pkg::wpe_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wpe_pkg::wpe_cmd_t data_o
);

  wpe_pkg::wpe_cmd_t entry_q [2];
  logic              wptr_q;
  logic              rptr_q;
  logic [1:0]        cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/wpe_back.sv =====
// ----------------------------------------------------------------------------
// wpe_back
// Admits commands against the budgets, expands them into lines one vertex
// write per step, serves read-back and issues the result.
// ----------------------------------------------------------------------------
module wpe_back #(
  parameter int unsigned VERTEX_DEPTH    = wpe_pkg::VERTEX_DEPTH_DEF,
  parameter int unsigned PRIMITIVE_LIMIT = wpe_pkg::PRIMITIVE_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  wpe_pkg::wpe_cmd_t cmd_i,
  output logic              pop_o,
  output logic              done_o,
  output wpe_pkg::wpe_rsp_t rsp_o
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LINE, S_LOOK, S_MUL, S_WRITE} state_e;

  localparam int unsigned AW   = $clog2(VERTEX_DEPTH);
  localparam int unsigned WV_W = $clog2(VERTEX_DEPTH + 1);
  localparam int unsigned PC_W = $clog2(PRIMITIVE_LIMIT + 1);
  localparam int unsigned SW   = wpe_pkg::SEG_W;
  localparam int unsigned LW   = wpe_pkg::LINE_W;
  localparam int unsigned TB   = wpe_pkg::TAB_BITS;

  state_e            state_q, state_d;
  wpe_pkg::wpe_cmd_t cmd_q, cmd_d;
  logic [WV_W-1:0]   wv_q, wv_d;
  logic [PC_W-1:0]   adm_q, adm_d;
  logic              drop_q, drop_d;
  logic [LW-1:0]     line_q, line_d;
  logic              end_q, end_d;
  logic [1:0]        circ_q, circ_d;
  logic [SW-1:0]     k_q, k_d;
  logic [12:0]       ph_q, ph_d;
  logic [SW:0]       rem_q, rem_d;
  logic [TB:0]       cos_q, cos_d;
  logic [TB:0]       sin_q, sin_d;
  logic [47:0]       cprod_q, cprod_d;
  logic [47:0]       sprod_q, sprod_d;
  logic              done_q, done_d;
  wpe_pkg::wpe_rsp_t rsp_q, rsp_d;

  logic              emit;
  logic              adv;
  logic              sphere;
  logic [SW+1:0]     rsum;
  logic [12:0]       ph_n;
  logic [SW:0]       rem_n;
  logic [11:0]       phase;
  logic [47:0]       cr;
  logic [47:0]       sr;
  logic signed [32:0] coff;
  logic signed [32:0] soff;
  logic signed [31:0] fv [3];
  logic signed [31:0] sv [3];
  logic signed [31:0] base [3];
  logic signed [32:0] off [3];
  logic signed [31:0] vtx [3];
  logic [2:0]        corner;
  logic [1:0]        la;
  logic [1:0]        lb;
  logic signed [32:0] size_x;

  logic              ram_we;
  logic              ram_re;
  logic [127:0]      ram_rdata;

  assign sphere = (cmd_q.req.func == wpe_pkg::FN_SPHERE);

  // phase of the next circle point: q += step_q, r += step_r, carry at 2n
  assign rsum = {1'b0, rem_q} + {2'b0, cmd_q.step_r};
  always_comb begin
    if (rsum >= {1'b0, cmd_q.segs, 1'b0}) begin
      ph_n  = ph_q + 13'(cmd_q.step_q) + 13'd1;
      rem_n = (SW+1)'(rsum - {1'b0, cmd_q.segs, 1'b0});
    end else begin
      ph_n  = ph_q + 13'(cmd_q.step_q);
      rem_n = (SW+1)'(rsum);
    end
  end

  assign phase = end_q ? ph_n[11:0] : ph_q[11:0];

  // scaled circle offsets, rounded half away from zero
  assign cr   = cprod_q + 48'd32768;
  assign sr   = sprod_q + 48'd32768;
  assign coff = cos_q[TB] ? -$signed({1'b0, cr[47:16]}) : $signed({1'b0, cr[47:16]});
  assign soff = sin_q[TB] ? -$signed({1'b0, sr[47:16]}) : $signed({1'b0, sr[47:16]});

  // circle planes xy, xz, yz
  always_comb begin
    case (circ_q)
      2'd0:    begin la = 2'd0; lb = 2'd1; end
      2'd1:    begin la = 2'd0; lb = 2'd2; end
      default: begin la = 2'd1; lb = 2'd2; end
    endcase
  end

  assign fv[0]  = cmd_q.req.first_x;
  assign fv[1]  = cmd_q.req.first_y;
  assign fv[2]  = cmd_q.req.first_z;
  assign sv[0]  = cmd_q.req.second_x;
  assign sv[1]  = cmd_q.req.second_y;
  assign sv[2]  = cmd_q.req.second_z;
  assign corner = wpe_pkg::box_corner(line_q[3:0], end_q);
  assign size_x = {cmd_q.req.size[31], cmd_q.req.size};

  // vertex coordinates of the current line end
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      base[a] = fv[a];
      off[a]  = '0;
      case (cmd_q.req.func)
        wpe_pkg::FN_POINT: begin
          if (line_q == LW'(a)) off[a] = end_q ? size_x : -size_x;
        end
        wpe_pkg::FN_AXES: begin
          if (line_q == LW'(a) && end_q) off[a] = size_x;
        end
        wpe_pkg::FN_BOX: begin
          base[a] = corner[a] ? sv[a] : fv[a];
        end
        wpe_pkg::FN_SPHERE: begin
          if (la == 2'(a)) off[a] = coff;
          else if (lb == 2'(a)) off[a] = soff;
        end
        wpe_pkg::FN_EDGE: begin
          base[a] = end_q ? sv[a] : fv[a];
        end
        default: begin
          base[a] = fv[a];
        end
      endcase
      vtx[a] = wpe_pkg::sat_add(base[a], off[a]);
    end
  end

  // command sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    wv_d    = wv_q;
    adm_d   = adm_q;
    drop_d  = drop_q;
    line_d  = line_q;
    end_d   = end_q;
    circ_d  = circ_q;
    k_d     = k_q;
    ph_d    = ph_q;
    rem_d   = rem_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    cprod_d = cprod_q;
    sprod_d = sprod_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    emit    = 1'b0;
    adv     = 1'b0;
    pop_o   = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          case (cmd_i.req.func)
            wpe_pkg::FN_BEGIN: begin
              wv_d   = '0;
              adm_d  = '0;
              drop_d = 1'b0;
              emit   = 1'b1;
            end
            wpe_pkg::FN_READ: begin
              if (17'(cmd_i.req.read_index) < 17'(VERTEX_DEPTH)) begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end else begin
                emit = 1'b1;
              end
            end
            wpe_pkg::FN_POINT, wpe_pkg::FN_AXES, wpe_pkg::FN_BOX,
            wpe_pkg::FN_SPHERE, wpe_pkg::FN_EDGE: begin
              // primitive admission
              if (drop_q) begin
                emit = 1'b1;
              end else if (adm_q >= PC_W'(PRIMITIVE_LIMIT)) begin
                drop_d = 1'b1;
                emit   = 1'b1;
              end else begin
                adm_d = adm_q + 1'b1;
                if (cmd_i.draws) begin
                  line_d  = '0;
                  end_d   = 1'b0;
                  circ_d  = '0;
                  k_d     = '0;
                  ph_d    = '0;
                  rem_d   = {1'b0, cmd_i.segs};
                  state_d = S_LINE;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_READ: begin
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      S_LINE: begin
        // vertex budget per line
        if (wv_q > WV_W'(VERTEX_DEPTH - 2)) begin
          drop_d = 1'b1;
          adv    = 1'b1;
        end else begin
          end_d   = 1'b0;
          state_d = sphere ? S_LOOK : S_WRITE;
        end
      end
      S_LOOK: begin
        cos_d   = wpe_pkg::sine_at(phase + 12'd1024);
        sin_d   = wpe_pkg::sine_at(phase);
        state_d = S_MUL;
      end
      S_MUL: begin
        cprod_d = 48'(cos_q[TB-1:0]) * 48'(cmd_q.req.size[30:0]);
        sprod_d = 48'(sin_q[TB-1:0]) * 48'(cmd_q.req.size[30:0]);
        state_d = S_WRITE;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        wv_d   = wv_q + 1'b1;
        if (!end_q) begin
          end_d   = 1'b1;
          state_d = sphere ? S_LOOK : S_WRITE;
        end else begin
          adv = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // step to the next line of the primitive
    if (adv) begin
      if (LW'(line_q + 1'b1) == cmd_q.lines) begin
        emit    = 1'b1;
        state_d = S_IDLE;
      end else begin
        line_d  = line_q + 1'b1;
        state_d = S_LINE;
        if (k_q == cmd_q.segs - 1'b1) begin
          k_d    = '0;
          circ_d = circ_q + 2'd1;
          ph_d   = '0;
          rem_d  = {1'b0, cmd_q.segs};
        end else begin
          k_d   = k_q + 1'b1;
          ph_d  = ph_n;
          rem_d = rem_n;
        end
      end
    end

    // result
    if (emit) begin
      done_d             = 1'b1;
      rsp_d.vertex_count = 16'(wv_d);
      rsp_d.truncated    = drop_d;
      rsp_d.read_x       = '0;
      rsp_d.read_y       = '0;
      rsp_d.read_z       = '0;
      rsp_d.read_color   = '0;
      if (state_q == S_READ) begin
        rsp_d.read_x     = ram_rdata[31:0];
        rsp_d.read_y     = ram_rdata[63:32];
        rsp_d.read_z     = ram_rdata[95:64];
        rsp_d.read_color = ram_rdata[127:96];
      end
    end
  end

  // vertex store: {color, z, y, x}
  wpe_ram #(
    .WIDTH (128),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(wv_q)),
    .wdata_i ({cmd_q.req.color, vtx[2], vtx[1], vtx[0]}),
    .re_i    (ram_re),
    .raddr_i (AW'(cmd_i.req.read_index)),
    .rdata_o (ram_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wv_q    <= '0;
      adm_q   <= '0;
      drop_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wv_q    <= wv_d;
      adm_q   <= adm_d;
      drop_q  <= drop_d;
      done_q  <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    line_q  <= line_d;
    end_q   <= end_d;
    circ_q  <= circ_d;
    k_q     <= k_d;
    ph_q    <= ph_d;
    rem_q   <= rem_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
    cprod_q <= cprod_d;
    sprod_q <= sprod_d;
    rsp_q   <= rsp_d;
  end

endmodule

// ===== hdl/wireframe_primitive_expander_core.sv =====
// ----------------------------------------------------------------------------
// wireframe_primitive_expander_core
// Expands debug primitives into a line-list vertex store with read-back.
// ----------------------------------------------------------------------------
// Usage: a request is taken on a rising edge with start_i high and busy_o low.
// Each request gives exactly one result on rsp_o, marked by done_o for one
// cycle; results come in request order and cannot be held off.
// The front end holds a request (a sphere first runs an 8192 / 2n divider one
// bit per cycle), then queues it when the queue is not full; a two-entry queue
// lets new requests in while the back end works. The back end takes a command,
// then per line runs a budget check followed by the two vertex writes: point
// and axes give 3 lines, a box 12, an edge 1; a sphere gives 3n lines, each
// vertex passing through table look-up, multiply and the write with its
// saturating add. A line over the vertex budget gets only its check. Begin
// batch, no-op and skipped primitives give their result from the idle state,
// read-back through the registered store port. Every result then passes
// through an output register.
// Reset clears the counters, the truncated flag and the queue; the vertex
// store is not cleared and reading a slot never written returns garbage.
// ----------------------------------------------------------------------------
module wireframe_primitive_expander_core #(
  parameter int unsigned VERTEX_DEPTH    = wpe_pkg::VERTEX_DEPTH_DEF,
  parameter int unsigned PRIMITIVE_LIMIT = wpe_pkg::PRIMITIVE_LIMIT_DEF,
  parameter int unsigned MAX_SEGMENTS    = wpe_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  wpe_pkg::wpe_req_t req_i,
  output logic              done_o,
  output wpe_pkg::wpe_rsp_t rsp_o
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  wpe_pkg::wpe_cmd_t q_in;
  wpe_pkg::wpe_cmd_t q_out;

  // request intake and classification
  wpe_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .cmd_o   (q_in)
  );

  // command queue
  wpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  // expansion and read-back
  wpe_back #(
    .VERTEX_DEPTH    (VERTEX_DEPTH),
    .PRIMITIVE_LIMIT (PRIMITIVE_LIMIT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (q_out),
    .pop_o   (q_pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // busy_o is raised after a taken request, holding off the next one
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised after request");

  // vertices are written in pairs
  a_even_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !rsp_o.vertex_count[0]) else $error("odd vertex count");

endmodule
